// ===== rtl/core/sen_pkg.sv =====
// shared constants, codes and types for the shared edge neighbour matcher
package sen_pkg;

    localparam int TABLE_ENTRIES_DEF = 1024;

    localparam int CELL_W   = 16;
    localparam int SLOT_W   = 3;
    localparam int VERT_W   = 20;
    localparam int KEY_W    = 2 * VERT_W;
    localparam int OWNER_W  = CELL_W + SLOT_W;
    localparam int STATUS_W = 2;

    localparam logic [STATUS_W-1:0] ST_STORED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MATCHED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

    // table entry occupancy codes
    localparam int ENT_W = 2;
    localparam logic [ENT_W-1:0] ENT_EMPTY = 2'd0;
    localparam logic [ENT_W-1:0] ENT_USED  = 2'd1;
    localparam logic [ENT_W-1:0] ENT_GONE  = 2'd2;

    typedef logic [CELL_W-1:0]   cell_t;
    typedef logic [SLOT_W-1:0]   slot_t;
    typedef logic [VERT_W-1:0]   vert_t;
    typedef logic [KEY_W-1:0]    key_t;
    typedef logic [STATUS_W-1:0] status_t;

endpackage

// ===== rtl/core/sen_if.sv =====
// request and result channel interfaces
interface sen_in_if;
    import sen_pkg::*;
    logic  valid;
    logic  ready;
    cell_t cell_id;
    slot_t edge_slot;
    vert_t vertex_a;
    vert_t vertex_b;
    modport source (output valid, cell_id, edge_slot, vertex_a, vertex_b, input ready);
    modport sink   (input valid, cell_id, edge_slot, vertex_a, vertex_b, output ready);
endinterface

interface sen_out_if;
    import sen_pkg::*;
    logic    valid;
    logic    ready;
    status_t status;
    cell_t   this_cell;
    slot_t   this_slot;
    cell_t   partner_cell;
    slot_t   partner_slot;
    modport source (output valid, status, this_cell, this_slot, partner_cell, partner_slot,
                    input ready);
    modport sink   (input valid, status, this_cell, this_slot, partner_cell, partner_slot,
                    output ready);
endinterface

// ===== rtl/core/sen_front.sv =====
// front stage: orders the vertices into a key and computes the probe start
module sen_front #(
    parameter int TABLE_ENTRIES = sen_pkg::TABLE_ENTRIES_DEF,
    parameter int QW = sen_pkg::KEY_W + $clog2(TABLE_ENTRIES) + sen_pkg::OWNER_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  sen_pkg::cell_t   in_cell,
    input  sen_pkg::slot_t   in_slot,
    input  sen_pkg::vert_t   in_va,
    input  sen_pkg::vert_t   in_vb,
    output logic             q_valid,
    input  logic             q_ready,
    output logic [QW-1:0]    q_data
);
    import sen_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    logic          valid_reg;
    logic [QW-1:0] data_reg;
    key_t          key;
    logic [IDX_W-1:0] fold;
    logic [IDX_W:0]   fold_x;
    logic [IDX_W-1:0] start;

    always_comb
    begin
        key = (in_va < in_vb) ? {in_va, in_vb} : {in_vb, in_va};
        fold = '0;
        for (int i = 0; i < KEY_W; i++)
        begin
            fold[i % IDX_W] = fold[i % IDX_W] ^ key[i];
        end
        fold_x = {1'b0, fold};
        // fold is below twice the table size
        if (fold_x >= (IDX_W+1)'(TABLE_ENTRIES))
        begin
            fold_x = fold_x - (IDX_W+1)'(TABLE_ENTRIES);
        end
        start = fold_x[IDX_W-1:0];
    end

    assign in_ready = !valid_reg || q_ready;
    assign q_valid  = valid_reg;
    assign q_data   = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= {key, start, in_cell, in_slot};
        end
    end

endmodule

// ===== rtl/core/sen_queue.sv =====
// two-entry queue between the front and back parts
module sen_queue #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr_valid,
    output logic         wr_ready,
    input  logic [W-1:0] wr_data,
    output logic         rd_valid,
    input  logic         rd_ready,
    output logic [W-1:0] rd_data
);
    logic [W-1:0] mem_reg [2];
    logic         wp_reg;
    logic         rp_reg;
    logic [1:0]   cnt_reg;
    logic         push;
    logic         pop;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rp_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= !wp_reg;
            end
            if (pop)
            begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

endmodule

// ===== rtl/core/sen_back.sv =====
// back part: probes the hashed edge table, matches, stores or reports full
module sen_back #(
    parameter int TABLE_ENTRIES = sen_pkg::TABLE_ENTRIES_DEF,
    parameter int QW = sen_pkg::KEY_W + $clog2(TABLE_ENTRIES) + sen_pkg::OWNER_W
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    output logic                q_ready,
    input  logic [QW-1:0]       q_data,
    output logic                out_valid,
    input  logic                out_ready,
    output sen_pkg::status_t    out_status,
    output sen_pkg::cell_t      out_this_cell,
    output sen_pkg::slot_t      out_this_slot,
    output sen_pkg::cell_t      out_partner_cell,
    output sen_pkg::slot_t      out_partner_slot
);
    import sen_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int MEM_W = ENT_W + KEY_W + OWNER_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_ISSUE = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;

    logic [MEM_W-1:0] mem [TABLE_ENTRIES];
    logic [MEM_W-1:0] rd_reg;

    logic [2:0]       state_reg, state_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    logic [IDX_W-1:0] steps_reg, steps_next;
    logic [IDX_W-1:0] free_pos_reg, free_pos_next;
    logic             free_found_reg, free_found_next;
    key_t             key_reg;
    logic [OWNER_W-1:0] owner_reg;
    logic             load;

    logic             out_valid_reg, out_valid_next;
    status_t          status_reg, status_next;
    logic [OWNER_W-1:0] partner_reg, partner_next;

    logic             mem_we;
    logic [IDX_W-1:0] mem_wa;
    logic [MEM_W-1:0] mem_wd;

    logic [ENT_W-1:0]   rd_ent;
    key_t               rd_key;
    logic [OWNER_W-1:0] rd_owner;
    logic [IDX_W-1:0]   ins_pos;

    assign rd_ent   = rd_reg[MEM_W-1 -: ENT_W];
    assign rd_key   = rd_reg[OWNER_W +: KEY_W];
    assign rd_owner = rd_reg[OWNER_W-1:0];
    assign ins_pos  = free_found_reg ? free_pos_reg : pos_reg;

    assign q_ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign load    = q_ready && q_valid;

    assign out_valid        = out_valid_reg;
    assign out_status       = status_reg;
    assign out_this_cell    = owner_reg[OWNER_W-1:SLOT_W];
    assign out_this_slot    = owner_reg[SLOT_W-1:0];
    assign out_partner_cell = partner_reg[OWNER_W-1:SLOT_W];
    assign out_partner_slot = partner_reg[SLOT_W-1:0];

    always_comb
    begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        steps_next      = steps_reg;
        free_pos_next   = free_pos_reg;
        free_found_next = free_found_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        status_next     = status_reg;
        partner_next    = partner_reg;
        mem_we          = 1'b0;
        mem_wa          = pos_reg;
        mem_wd          = '0;
        case (state_reg)
            S_CLEAR:
            begin
                mem_we   = 1'b1;
                mem_wd   = {ENT_EMPTY, {(KEY_W + OWNER_W){1'b0}}};
                pos_next = pos_reg + 1'b1;
                if (pos_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (load)
                begin
                    pos_next        = q_data[OWNER_W +: IDX_W];
                    steps_next      = '0;
                    free_found_next = 1'b0;
                    state_next      = S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (rd_ent == ENT_USED && rd_key == key_reg)
                begin
                    mem_we         = 1'b1;
                    mem_wd         = {ENT_GONE, rd_key, rd_owner};
                    status_next    = ST_MATCHED;
                    partner_next   = rd_owner;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else if (rd_ent == ENT_EMPTY)
                begin
                    // no further copy of the key can sit past an empty entry
                    mem_we         = 1'b1;
                    mem_wa         = ins_pos;
                    mem_wd         = {ENT_USED, key_reg, owner_reg};
                    status_next    = ST_STORED;
                    partner_next   = '0;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else if (steps_reg == LAST_IDX)
                begin
                    partner_next   = '0;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    if (free_found_reg || rd_ent != ENT_USED)
                    begin
                        mem_we      = 1'b1;
                        mem_wa      = ins_pos;
                        mem_wd      = {ENT_USED, key_reg, owner_reg};
                        status_next = ST_STORED;
                    end
                    else
                    begin
                        status_next = ST_FULL;
                    end
                end
                else
                begin
                    if (rd_ent != ENT_USED && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_pos_next   = pos_reg;
                    end
                    steps_next = steps_reg + 1'b1;
                    pos_next   = (pos_reg == LAST_IDX) ? '0 : pos_reg + 1'b1;
                    state_next = S_ISSUE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            pos_reg        <= '0;
            steps_reg      <= '0;
            free_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pos_reg        <= pos_next;
            steps_reg      <= steps_next;
            free_found_reg <= free_found_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        free_pos_reg <= free_pos_next;
        status_reg   <= status_next;
        partner_reg  <= partner_next;
        if (load)
        begin
            key_reg   <= q_data[QW-1 -: KEY_W];
            owner_reg <= q_data[OWNER_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_reg <= mem[pos_reg];
    end

endmodule

// ===== rtl/core/shared_edge_neighbour_matcher.sv =====
// each table probe reads an entry into a register, then checks it against the key
// the back part takes a new request only when idle and after the last result is taken
// probes run from the hashed start to a matching key or the first empty entry, at most TABLE_ENTRIES
// a result waits in its output register while the next request is taken into the queue
// reset: asynchronous active low, then a clearing pass over all TABLE_ENTRIES entries
//   before the first request reaches the table
module shared_edge_neighbour_matcher #(
    parameter int TABLE_ENTRIES = sen_pkg::TABLE_ENTRIES_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    sen_in_if.sink          item,
    sen_out_if.source       result
);
    import sen_pkg::*;

    localparam int QW = KEY_W + $clog2(TABLE_ENTRIES) + OWNER_W;

    logic          fq_valid, fq_ready;
    logic [QW-1:0] fq_data;
    logic          qb_valid, qb_ready;
    logic [QW-1:0] qb_data;

    sen_front #(.TABLE_ENTRIES(TABLE_ENTRIES), .QW(QW)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_ready (item.ready),
        .in_cell  (item.cell_id),
        .in_slot  (item.edge_slot),
        .in_va    (item.vertex_a),
        .in_vb    (item.vertex_b),
        .q_valid  (fq_valid),
        .q_ready  (fq_ready),
        .q_data   (fq_data)
    );

    sen_queue #(.W(QW)) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_data  (fq_data),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_data  (qb_data)
    );

    sen_back #(.TABLE_ENTRIES(TABLE_ENTRIES), .QW(QW)) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_valid          (qb_valid),
        .q_ready          (qb_ready),
        .q_data           (qb_data),
        .out_valid        (result.valid),
        .out_ready        (result.ready),
        .out_status       (result.status),
        .out_this_cell    (result.this_cell),
        .out_this_slot    (result.this_slot),
        .out_partner_cell (result.partner_cell),
        .out_partner_slot (result.partner_slot)
    );

endmodule

// ===== rtl/core/sen_checker.sv =====
// port-level checks for the shared edge neighbour matcher
module sen_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             res_valid,
    input logic             res_ready,
    input sen_pkg::status_t res_status,
    input sen_pkg::cell_t   res_partner_cell,
    input sen_pkg::slot_t   res_partner_slot,
    input sen_pkg::cell_t   res_this_cell
);
    import sen_pkg::*;

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    a_cell_holds: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res_this_cell) && $stable(res_status))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_status == ST_STORED || res_status == ST_MATCHED ||
                       res_status == ST_FULL))
        else $error("undefined status code");

    a_partner_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_status != ST_MATCHED |->
            res_partner_cell == '0 && res_partner_slot == '0)
        else $error("partner fields set without a match");

endmodule

bind shared_edge_neighbour_matcher sen_checker u_sen_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .res_valid        (result.valid),
    .res_ready        (result.ready),
    .res_status       (result.status),
    .res_partner_cell (result.partner_cell),
    .res_partner_slot (result.partner_slot),
    .res_this_cell    (result.this_cell)
);
